// File: design/bvrs_pkg.sv
// ----------------------------------------------------------------------------
// Bit vector rank and select package
// Shared widths, reset values, action codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bvrs_pkg;

    localparam int MAX_BITS_DEF  = 4096;
    localparam int WORD_BITS_DEF = 64;

    localparam int ACT_W = 3;
    localparam int POS_W = 12;
    localparam int LEN_W = 13;

    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    typedef enum logic [ACT_W-1:0] {
        ACT_SET    = 3'd0,
        ACT_CLEAR  = 3'd1,
        ACT_TOGGLE = 3'd2,
        ACT_TEST   = 3'd3,
        ACT_RANK   = 3'd4,
        ACT_SELECT = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_WALK,
        ST_DRAIN,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_single;
        logic modify;
        logic walk_issue;
        logic walk_proc;
        logic scan_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic kind_bit;
        logic kind_walk;
        logic issue_last;
        logic hit;
        logic scan_found;
        logic out_blocked;
    } t_status;

endpackage

`default_nettype wire

// File: design/bit_vector_rank_select_core.sv
// ----------------------------------------------------------------------------
// Bit vector rank and select core
// A bit store of 64-bit words with set, clear, toggle, test, rank and select.
//
//   Channel   Handshake             Payload
//   input     i_valid / o_stall     i_action, i_position, i_target_count
//   output    o_valid / i_stall     o_bit_value, o_ones_count,
//                                   o_found_position, o_found, o_index_error
//   config    i_cfg_wr_en           i_cfg_wr_data (vector length)
//
// Set, clear, toggle and test pass through the read and modify states before the result is emitted.
// Rank and select read one store word per cycle from the single memory port
// while walking the words; a select stops the walk at the hit word and then
// scans that word one bit per cycle.
// Errors and undefined actions go straight from idle to the done state.
// Reset is synchronous and clears the store valid bits at once; no sweep.
// A result waits in the output register while stalled; the next item is taken
// once the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_vector_rank_select_core #(
    parameter int MAX_BITS  = bvrs_pkg::MAX_BITS_DEF,
    parameter int WORD_BITS = bvrs_pkg::WORD_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_wr_en,
    input  wire  [bvrs_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  wire                        i_valid,
    output logic                       o_stall,
    input  wire  [bvrs_pkg::ACT_W-1:0] i_action,
    input  wire  [bvrs_pkg::POS_W-1:0] i_position,
    input  wire  [bvrs_pkg::LEN_W-1:0] i_target_count,
    output logic                       o_valid,
    input  wire                        i_stall,
    output logic                       o_bit_value,
    output logic [bvrs_pkg::LEN_W-1:0] o_ones_count,
    output logic [bvrs_pkg::POS_W-1:0] o_found_position,
    output logic                       o_found,
    output logic                       o_index_error
);
    import bvrs_pkg::*;

    t_cmd    cmd;
    t_status status;

    bvrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    bvrs_dp #(
        .MAX_BITS  (MAX_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_action         (i_action),
        .i_position       (i_position),
        .i_target_count   (i_target_count),
        .i_stall          (i_stall),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_bit_value      (o_bit_value),
        .o_ones_count     (o_ones_count),
        .o_found_position (o_found_position),
        .o_found          (o_found),
        .o_index_error    (o_index_error)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Input transfer was not followed by a busy cycle.");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_valid)
        else $error("Result was not presented after emit.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !(o_valid && i_stall))
        else $error("Stalled result overwritten.");

    a_one_port_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.rd_single, cmd.walk_issue, cmd.scan_step}))
        else $error("Conflicting datapath commands.");

endmodule

`default_nettype wire

// File: design/bvrs_ctrl.sv
// ----------------------------------------------------------------------------
// Bit vector rank and select controller
// Sequences one item at a time through single-bit access, the word walk of
// rank and select, the bit scan of select, and the result transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bvrs_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    input  bvrs_pkg::t_status i_status,
    output logic              o_stall,
    output bvrs_pkg::t_cmd    o_cmd
);
    import bvrs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_status.kind_bit) begin
                        n_state = ST_READ;
                    end else if (i_status.kind_walk) begin
                        n_state = ST_WALK;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_READ:   n_state = ST_MODIFY;
            ST_MODIFY: n_state = ST_DONE;
            ST_WALK: begin
                if (i_status.hit) begin
                    n_state = ST_SCAN;
                end else if (i_status.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_status.hit) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_found) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_status.out_blocked) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_READ:   o_cmd.rd_single = 1'b1;
            ST_MODIFY: o_cmd.modify = 1'b1;
            ST_WALK: begin
                o_cmd.walk_issue = !i_status.hit;
                o_cmd.walk_proc  = 1'b1;
            end
            ST_DRAIN:  o_cmd.walk_proc = 1'b1;
            ST_SCAN:   o_cmd.scan_step = 1'b1;
            ST_DONE:   o_cmd.emit = !i_status.out_blocked;
            default:   o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/bvrs_dp.sv
// ----------------------------------------------------------------------------
// Bit vector rank and select datapath
// Word store with reset-cleared valid bits, length register, item registers,
// masked word popcount and accumulator, select bit scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bvrs_dp #(
    parameter int MAX_BITS  = bvrs_pkg::MAX_BITS_DEF,
    parameter int WORD_BITS = bvrs_pkg::WORD_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_wr_en,
    input  wire  [bvrs_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  wire  [bvrs_pkg::ACT_W-1:0] i_action,
    input  wire  [bvrs_pkg::POS_W-1:0] i_position,
    input  wire  [bvrs_pkg::LEN_W-1:0] i_target_count,
    input  wire                        i_stall,
    input  bvrs_pkg::t_cmd             i_cmd,
    output bvrs_pkg::t_status          o_status,
    output logic                       o_valid,
    output logic                       o_bit_value,
    output logic [bvrs_pkg::LEN_W-1:0] o_ones_count,
    output logic [bvrs_pkg::POS_W-1:0] o_found_position,
    output logic                       o_found,
    output logic                       o_index_error
);
    import bvrs_pkg::*;

    localparam int NUM_WORDS = MAX_BITS / WORD_BITS;
    localparam int WB_LG     = $clog2(WORD_BITS);
    localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int EL_W      = $clog2(MAX_BITS + 1);
    localparam int PC_W      = $clog2(WORD_BITS + 1);

    function automatic logic [PC_W-1:0] popcount(input logic [WORD_BITS-1:0] w);
        logic [PC_W-1:0] s;
        s = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            s = s + PC_W'(w[j]);
        end
        return s;
    endfunction

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_wvld;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rvld;

    logic [LEN_W-1:0]     r_len;
    logic [ACT_W-1:0]     r_act;
    logic [POS_W-1:0]     r_pos;
    logic [LEN_W-1:0]     r_k;
    logic                 r_err;
    logic [EL_W-1:0]      r_lim;
    logic [EL_W-1:0]      r_acc;
    logic [WA_W-1:0]      r_ra;
    logic [WA_W-1:0]      r_da;
    logic                 r_dv;
    logic [WORD_BITS-1:0] r_sword;
    logic [PC_W-1:0]      r_need;
    logic [WA_W-1:0]      r_sbase;
    logic [WB_LG-1:0]     r_bi;
    logic                 r_bitv;
    logic                 r_found;
    logic [POS_W-1:0]     r_fpos;
    logic                 r_ov;

    logic [EL_W-1:0]      eff_len;
    logic [LEN_W-1:0]     pos_p1;
    logic                 in_bitop;
    logic                 in_rank;
    logic                 in_sel;
    logic                 in_err;
    logic [EL_W-1:0]      n_lim;
    logic [EL_W-1:0]      pos_ext;
    logic [WA_W-1:0]      pos_word;
    logic [WB_LG-1:0]     pos_bit;
    logic [WA_W-1:0]      rd_addr;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] onehot;
    logic [WORD_BITS-1:0] mod_word;
    logic                 wr_en;
    logic [EL_W-1:0]      lim_m1;
    logic [WA_W-1:0]      last_word;
    logic [WB_LG-1:0]     lim_rem;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] masked;
    logic [EL_W-1:0]      sum;
    logic                 hit_now;
    logic                 scan_found;

    assign eff_len  = (r_len > MAX_BITS) ? EL_W'(MAX_BITS) : EL_W'(r_len);
    assign pos_p1   = {1'b0, i_position} + 1'b1;
    assign in_bitop = (i_action == ACT_SET) || (i_action == ACT_CLEAR)
                   || (i_action == ACT_TOGGLE) || (i_action == ACT_TEST);
    assign in_rank  = (i_action == ACT_RANK);
    assign in_sel   = (i_action == ACT_SELECT);

    always_comb begin
        in_err = 1'b0;
        n_lim  = eff_len;
        if (in_bitop) begin
            in_err = (i_position >= eff_len);
        end else if (in_rank) begin
            in_err = (i_position > eff_len);
            if (pos_p1 < eff_len) begin
                n_lim = EL_W'(pos_p1);
            end
        end else if (in_sel) begin
            in_err = (i_target_count == '0) || (i_target_count > eff_len);
        end
    end

    assign pos_ext  = EL_W'(r_pos);
    assign pos_word = pos_ext[WB_LG +: WA_W];
    assign pos_bit  = pos_ext[WB_LG-1:0];
    assign rd_addr  = i_cmd.rd_single ? pos_word : r_ra;
    assign word     = r_rvld ? r_rdata : '0;
    assign onehot   = WORD_BITS'(1) << pos_bit;

    always_comb begin
        mod_word = word;
        wr_en    = 1'b0;
        case (r_act)
            ACT_SET: begin
                mod_word = word | onehot;
                wr_en    = i_cmd.modify;
            end
            ACT_CLEAR: begin
                mod_word = word & ~onehot;
                wr_en    = i_cmd.modify;
            end
            ACT_TOGGLE: begin
                mod_word = word ^ onehot;
                wr_en    = i_cmd.modify;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[pos_word] <= mod_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
        end else if (wr_en) begin
            r_wvld[pos_word] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rvld <= r_wvld[rd_addr];
    end

    assign lim_m1    = r_lim - 1'b1;
    assign last_word = lim_m1[WB_LG +: WA_W];
    assign lim_rem   = r_lim[WB_LG-1:0];

    always_comb begin
        mask = '1;
        if ((r_da == last_word) && (lim_rem != '0)) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                mask[j] = (j < lim_rem);
            end
        end
    end

    assign masked     = word & mask;
    assign sum        = r_acc + EL_W'(popcount(masked));
    assign hit_now    = (r_act == ACT_SELECT) && r_dv && (sum >= r_k);
    assign scan_found = r_sword[0] && (r_need == PC_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv <= i_cmd.walk_issue;
        if (i_cmd.load) begin
            r_act   <= i_action;
            r_pos   <= i_position;
            r_k     <= i_target_count;
            r_err   <= in_err;
            r_lim   <= n_lim;
            r_acc   <= '0;
            r_ra    <= '0;
            r_bitv  <= 1'b0;
            r_found <= 1'b0;
            r_fpos  <= '0;
        end
        if (i_cmd.modify && (r_act == ACT_TEST)) begin
            r_bitv <= word[pos_bit];
        end
        if (i_cmd.walk_issue) begin
            r_ra <= r_ra + 1'b1;
            r_da <= r_ra;
        end
        if (i_cmd.walk_proc && r_dv) begin
            r_acc <= sum;
            if (hit_now) begin
                r_sword <= masked;
                r_need  <= PC_W'(r_k - r_acc);
                r_sbase <= r_da;
                r_bi    <= '0;
            end
        end
        if (i_cmd.scan_step) begin
            if (scan_found) begin
                r_found <= 1'b1;
                r_fpos  <= POS_W'({r_sbase, r_bi});
            end else begin
                if (r_sword[0]) begin
                    r_need <= r_need - 1'b1;
                end
                r_sword <= r_sword >> 1;
                r_bi    <= r_bi + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_bit_value      <= r_bitv;
            o_ones_count     <= (r_act == ACT_RANK) ? LEN_W'(r_acc) : '0;
            o_found_position <= r_fpos;
            o_found          <= r_found;
            o_index_error    <= r_err;
        end
    end

    assign o_valid              = r_ov;
    assign o_status.kind_bit    = in_bitop && !in_err;
    assign o_status.kind_walk   = (in_rank || in_sel) && !in_err && (n_lim != '0);
    assign o_status.issue_last  = (r_ra == last_word);
    assign o_status.hit         = hit_now;
    assign o_status.scan_found  = scan_found;
    assign o_status.out_blocked = r_ov && i_stall;

endmodule

`default_nettype wire

// File: tb/sv/bvrs_checker.sv
// ----------------------------------------------------------------------------
// Bit vector rank and select checker
// Watches the input and output channels and the length register writes, keeps
// its own copy of the bit store, predicts each result and compares it field
// by field with what the core returns.
// ----------------------------------------------------------------------------
`default_nettype none

module bvrs_checker (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_wr_en,
    input  wire  [bvrs_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  wire                        i_in_valid,
    input  wire                        i_in_stall,
    input  wire  [bvrs_pkg::ACT_W-1:0] i_action,
    input  wire  [bvrs_pkg::POS_W-1:0] i_position,
    input  wire  [bvrs_pkg::LEN_W-1:0] i_target_count,
    input  wire                        i_out_valid,
    input  wire                        i_out_stall,
    input  wire                        i_bit_value,
    input  wire  [bvrs_pkg::LEN_W-1:0] i_ones_count,
    input  wire  [bvrs_pkg::POS_W-1:0] i_found_position,
    input  wire                        i_found,
    input  wire                        i_index_error,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results
);
    import bvrs_pkg::*;

    typedef struct packed {
        logic             bit_value;
        logic [LEN_W-1:0] ones_count;
        logic [POS_W-1:0] found_position;
        logic             found;
        logic             index_error;
    } t_answer;

    logic [4095:0] bits;
    logic [LEN_W-1:0] length_reg;
    t_answer answers[$];

    function automatic t_answer compute_answer(input logic [ACT_W-1:0] act,
                                               input logic [POS_W-1:0] pos,
                                               input logic [LEN_W-1:0] k);
        t_answer a;
        int len;
        int lim;
        int c;
        a = '0;
        len = (length_reg > 4096) ? 4096 : int'(length_reg);
        case (act)
            ACT_SET, ACT_CLEAR, ACT_TOGGLE, ACT_TEST: begin
                if (int'(pos) >= len) begin
                    a.index_error = 1'b1;
                end else if (act == ACT_SET) begin
                    bits[pos] = 1'b1;
                end else if (act == ACT_CLEAR) begin
                    bits[pos] = 1'b0;
                end else if (act == ACT_TOGGLE) begin
                    bits[pos] = ~bits[pos];
                end else begin
                    a.bit_value = bits[pos];
                end
            end
            ACT_RANK: begin
                if (int'(pos) > len) begin
                    a.index_error = 1'b1;
                end else begin
                    lim = (int'(pos) + 1 < len) ? int'(pos) + 1 : len;
                    for (int i = 0; i < lim; i++) a.ones_count += bits[i];
                end
            end
            ACT_SELECT: begin
                if (k == 0 || int'(k) > len) begin
                    a.index_error = 1'b1;
                end else begin
                    c = 0;
                    for (int i = 0; i < len; i++) begin
                        if (bits[i] && !a.found) begin
                            c++;
                            if (c == int'(k)) begin
                                a.found_position = i[POS_W-1:0];
                                a.found = 1'b1;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    assign o_pending = answers.size();

    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            bits <= '0;
            length_reg <= LEN_RESET;
            o_errors <= 0;
            o_results <= 0;
            answers.delete();
        end else begin
            if (i_cfg_wr_en) length_reg <= i_cfg_wr_data;
            if (i_in_valid && !i_in_stall)
                answers.push_back(compute_answer(i_action, i_position, i_target_count));
            if (i_out_valid && !i_out_stall) begin
                got = {i_bit_value, i_ones_count, i_found_position, i_found, i_index_error};
                o_results <= o_results + 1;
                if (answers.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answers.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected bit %0d ones %0d pos %0d found %0d err %0d",
                                 $time, want.bit_value, want.ones_count, want.found_position,
                                 want.found, want.index_error);
                        $display("%0t:          actual   bit %0d ones %0d pos %0d found %0d err %0d",
                                 $time, got.bit_value, got.ones_count, got.found_position,
                                 got.found, got.index_error);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Bit vector rank and select testbench
// Drives directed and random bit operations, ranks and selects through
// several vector lengths with random gaps and stalls; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import bvrs_pkg::*;

    localparam int LIMIT = 2000000;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [ACT_W-1:0] action = '0;
    logic [POS_W-1:0] position = '0;
    logic [LEN_W-1:0] target_count = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             bit_value;
    logic [LEN_W-1:0] ones_count;
    logic [POS_W-1:0] found_position;
    logic             found;
    logic             index_error;
    int               errors;
    int               pending;
    int               results;
    int               cycles = 0;
    int               sent = 0;

    always #2 clk = ~clk;

    bit_vector_rank_select_core i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_action(action), .i_position(position), .i_target_count(target_count),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_bit_value(bit_value), .o_ones_count(ones_count),
        .o_found_position(found_position), .o_found(found), .o_index_error(index_error)
    );

    bvrs_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_action(action), .i_position(position), .i_target_count(target_count),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_bit_value(bit_value), .i_ones_count(ones_count),
        .i_found_position(found_position), .i_found(found), .i_index_error(index_error),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Receiver stall pattern: random stretches, with a calm phase in the middle.
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            n = gap_length();
            if (sent > 800 && sent < 1000) n = 0;
            out_stall <= (n != 0);
            repeat (n == 0 ? $urandom_range(1, 8) : n) @(posedge clk);
        end
    end

    task automatic send_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                             input logic [LEN_W-1:0] k);
        int g;
        g = (sent > 800 && sent < 1000) ? 0 : gap_length();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        position <= pos;
        target_count <= k;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly short lengths keep the walks short; a few phases use full size.
    task automatic random_phase(input logic [LEN_W-1:0] len, input int count);
        int span;
        int r;
        logic [ACT_W-1:0] act;
        logic [POS_W-1:0] pos;
        logic [LEN_W-1:0] k;
        set_length(len);
        span = (len > 4096) ? 4096 : int'(len);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            act = (r < 3) ? ACT_W'($urandom_range(6, 7)) :
                  (r < 35) ? ACT_SET : (r < 45) ? ACT_CLEAR : (r < 55) ? ACT_TOGGLE :
                  (r < 67) ? ACT_TEST : (r < 83) ? ACT_RANK : ACT_SELECT;
            if ($urandom_range(0, 9) == 0 || span == 0) pos = POS_W'($urandom);
            else pos = POS_W'($urandom_range(0, span - 1));
            if ($urandom_range(0, 9) == 0) k = LEN_W'($urandom);
            else k = LEN_W'($urandom_range(0, span / 2 + 1));
            send_item(act, pos, k);
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_item(ACT_SET, 12'd0, 13'd0);
        send_item(ACT_SET, 12'd4095, 13'd0);
        send_item(ACT_SET, 12'd63, 13'd0);
        send_item(ACT_TOGGLE, 12'd64, 13'd0);
        send_item(ACT_TEST, 12'd4095, 13'd0);
        send_item(ACT_TEST, 12'd1, 13'd0);
        send_item(ACT_RANK, 12'd4095, 13'd0);
        send_item(ACT_SELECT, 12'd0, 13'd4);
        send_item(ACT_SELECT, 12'd0, 13'd5);
        send_item(ACT_SELECT, 12'd0, 13'd0);
        send_item(ACT_SELECT, 12'd0, 13'd4096);
        send_item(ACT_CLEAR, 12'd63, 13'd0);
        send_item(3'd6, 12'hfff, 13'h1fff);
        send_item(3'd7, 12'd5, 13'd1);
        set_length(13'd100);
        send_item(ACT_SET, 12'd100, 13'd0);
        send_item(ACT_RANK, 12'd100, 13'd0);
        send_item(ACT_RANK, 12'd101, 13'd0);
        send_item(ACT_SELECT, 12'd0, 13'd101);
        send_item(ACT_SELECT, 12'd0, 13'h1fff);
        send_item(ACT_SELECT, 12'd0, 13'd2);
        set_length(13'h1fff);
        send_item(ACT_RANK, 12'd4095, 13'd0);
        set_length(13'd0);
        send_item(ACT_TEST, 12'd0, 13'd1);
        send_item(ACT_RANK, 12'd0, 13'd0);
        send_item(ACT_SELECT, 12'd0, 13'd1);
        random_phase(13'd200, 500);
        random_phase(13'd64, 300);
        random_phase(13'd4096, 300);
        random_phase(13'd1, 100);
        random_phase(13'd130, 500);
        random_phase(13'h1fff, 150);
        random_phase(13'd0, 50);
        random_phase(LEN_W'($urandom_range(0, 8191)), 100);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d items and %0d results over lengths 0, 1, 64, 100, 130, 200,",
                 sent, results);
        $display("4096 and above capacity, with bit edits, tests, ranks and selects.");
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
design/bvrs_pkg.sv
design/bvrs_ctrl.sv
design/bvrs_dp.sv
design/bit_vector_rank_select_core.sv
tb/sv/bvrs_checker.sv
tb/sv/testbench.sv
